@@ hdl/rna_pkg.sv @@
// Shared types, codes and limits for the rational number ALU.
// Used by every module of the block and by its checker; depends on nothing.
package rna_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int NUM_W           = 32;
    localparam int DEN_W           = 31;
    localparam int LIM_W           = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_GT = 2'd1;
    localparam logic [1:0] ORD_LT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [LIM_W-1:0] NUM_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [LIM_W-1:0] NUM_NEG_MAX = 64'h0000_0000_8000_0000;
    localparam logic [LIM_W-1:0] DEN_MAX     = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic [2:0]                 opcode;
        logic signed [FIELD_W-1:0]  num_a;
        logic signed [FIELD_W-1:0]  den_a;
        logic signed [FIELD_W-1:0]  num_b;
        logic signed [FIELD_W-1:0]  den_b;
    } t_in_word;

    typedef struct packed {
        logic signed [NUM_W-1:0]    res_num;
        logic [DEN_W-1:0]           res_den;
        logic [1:0]                 order;
        logic [1:0]                 status;
    } t_out_word;

endpackage

@@ hdl/rna_mul.sv @@
// Registered unsigned multiplier for operand magnitudes.
// Depends on rna_pkg for the default width.
module rna_mul import rna_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic [VALUE_WIDTH-1:0]     i_x,
    input  logic [VALUE_WIDTH-1:0]     i_y,
    output logic [2*VALUE_WIDTH-1:0]   o_prod
);

    localparam int PW = 2 * VALUE_WIDTH;

    logic [PW-1:0] r_prod;
    logic [PW-1:0] n_prod;

    assign n_prod = i_x * i_y;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/rna_core.sv @@
// Reduction unit: binary GCD of two magnitudes, then restoring division of both by it.
// One subtractor serves the GCD steps and the division steps. Depends on rna_pkg.
module rna_core import rna_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [2*VALUE_WIDTH-1:0]   i_nmag,
    input  logic [2*VALUE_WIDTH-1:0]   i_dmag,
    output logic                       o_done,
    output logic [2*VALUE_WIDTH-1:0]   o_nq,
    output logic [2*VALUE_WIDTH-1:0]   o_dq
);

    localparam int MW = 2 * VALUE_WIDTH;
    localparam int KW = $clog2(MW);
    localparam int CW = $clog2(MW);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_GCD   = 2'd1;
    localparam logic [1:0] C_SHIFT = 2'd2;
    localparam logic [1:0] C_DIV   = 2'd3;

    logic [1:0]    r_st,   n_st;
    logic [MW-1:0] r_u,    n_u;
    logic [MW-1:0] r_v,    n_v;
    logic [MW-1:0] r_n,    n_n;
    logic [MW-1:0] r_d,    n_d;
    logic [MW-1:0] r_g,    n_g;
    logic [KW-1:0] r_k,    n_k;
    logic [MW-1:0] r_rem,  n_rem;
    logic [MW-1:0] r_quo,  n_quo;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic          r_sel,  n_sel;
    logic [MW-1:0] r_nq,   n_nq;
    logic [MW-1:0] r_dq,   n_dq;
    logic          r_done, n_done;

    logic [MW:0]   sh;
    logic [MW:0]   sub_a;
    logic [MW:0]   sub_b;
    logic [MW:0]   sub_y;
    logic [MW:0]   alt_y;
    logic [MW-1:0] quo_step;
    logic [MW-1:0] rem_step;

    assign sh    = {r_rem, r_quo[MW-1]};
    assign sub_a = (r_st == C_DIV) ? sh : {1'b0, r_u};
    assign sub_b = (r_st == C_DIV) ? {1'b0, r_g} : {1'b0, r_v};
    assign sub_y = sub_a - sub_b;
    assign alt_y = {1'b0, r_v} - {1'b0, r_u};

    assign quo_step = {r_quo[MW-2:0], ~sub_y[MW]};
    assign rem_step = sub_y[MW] ? sh[MW-1:0] : sub_y[MW-1:0];

    always_comb begin
        n_st   = r_st;
        n_u    = r_u;
        n_v    = r_v;
        n_n    = r_n;
        n_d    = r_d;
        n_g    = r_g;
        n_k    = r_k;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_sel  = r_sel;
        n_nq   = r_nq;
        n_dq   = r_dq;
        n_done = 1'b0;
        case (r_st)
            C_IDLE: begin
                if (i_go) begin
                    n_u  = i_nmag;
                    n_v  = i_dmag;
                    n_n  = i_nmag;
                    n_d  = i_dmag;
                    n_k  = '0;
                    n_st = C_GCD;
                end
            end
            C_GCD: begin
                if (r_u == r_v) begin
                    n_st = C_SHIFT;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (!sub_y[MW]) begin
                    n_u = sub_y[MW:1];
                end else begin
                    n_v = alt_y[MW:1];
                end
            end
            C_SHIFT: begin
                n_g   = r_u << r_k;
                n_rem = '0;
                n_quo = r_n;
                n_cnt = CW'(MW - 1);
                n_sel = 1'b0;
                n_st  = C_DIV;
            end
            C_DIV: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (!r_sel) begin
                        n_nq  = quo_step;
                        n_rem = '0;
                        n_quo = r_d;
                        n_cnt = CW'(MW - 1);
                        n_sel = 1'b1;
                    end else begin
                        n_dq   = quo_step;
                        n_done = 1'b1;
                        n_st   = C_IDLE;
                    end
                end
            end
            default: begin
                n_st = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_u   <= n_u;
        r_v   <= n_v;
        r_n   <= n_n;
        r_d   <= n_d;
        r_g   <= n_g;
        r_k   <= n_k;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_sel <= n_sel;
        r_nq  <= n_nq;
        r_dq  <= n_dq;
    end

    assign o_done = r_done;
    assign o_nq   = r_nq;
    assign o_dq   = r_dq;

endmodule

@@ hdl/rational_number_alu.sv @@
// Top level of the rational number ALU: operand decode, product sequencer and result register.
// Depends on rna_pkg, rna_mul and rna_core.
//
// A word carries an opcode and two fractions num_a/den_a and num_b/den_b. It is taken at a
// rising edge where start is high and busy is low. Each word gives exactly one result word,
// shown on o_data for one cycle while o_strobe is high; the receiver cannot stall it.
// Words with an unused opcode, a zero denominator or a divide by a zero fraction are
// answered the cycle after they are taken, and busy stays low.
// Compare words and words whose sum or product is zero run the three products through the
// shared multiplier and finish in the check state, S_CHECK.
// All other words are reduced by the shared subtract and shift unit: G binary GCD steps,
// G at most 4*VALUE_WIDTH, then two restoring divisions of 2*VALUE_WIDTH steps each.
// Busy then stays high until the core is done, and the result is shown in the same cycle
// that busy falls.
// The next word may be started in the same cycle that the result is shown.
// Reset clears the sequencers; no result is pending after it.
module rational_number_alu import rna_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_data,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int MW = 2 * VALUE_WIDTH;
    localparam int RW = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_MUL3  = 3'd3;
    localparam logic [2:0] S_COMB  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_CORE  = 3'd6;

    function automatic logic [VW-1:0] take_value(input logic [FIELD_W-1:0] raw);
        logic [RW-1:0] ext;
        ext = RW'(raw);
        return ext[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] magnitude(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    logic [2:0]    r_st,     n_st;
    logic [2:0]    r_op,     n_op;
    logic [VW-1:0] r_ma,     n_ma;
    logic [VW-1:0] r_mb,     n_mb;
    logic [VW-1:0] r_mc,     n_mc;
    logic [VW-1:0] r_md,     n_md;
    logic          r_sa,     n_sa;
    logic          r_sb,     n_sb;
    logic          r_sc,     n_sc;
    logic          r_sd,     n_sd;
    logic [MW-1:0] r_p1,     n_p1;
    logic [MW-1:0] r_p2,     n_p2;
    logic [MW-1:0] r_nm,     n_nm;
    logic [MW-1:0] r_dm,     n_dm;
    logic          r_neg,    n_neg;
    logic          r_go,     n_go;
    logic          r_strobe, n_strobe;
    t_out_word     r_out,    n_out;

    logic [VW-1:0] va, vb, vc, vd;
    logic [VW-1:0] mul_x, mul_y;
    logic [MW-1:0] m_prod;

    logic          s1, s2, dneg, two_term;
    logic [MW-1:0] m2;
    logic [MW:0]   add_y, d12, d21;
    logic [MW-1:0] sum_mag;
    logic          sum_neg;

    logic          core_done;
    logic [MW-1:0] core_nq, core_dq;
    logic [LIM_W-1:0] nq_ext, dq_ext;
    logic [NUM_W-1:0] num_abs;
    logic             range_fail;

    assign va = take_value(i_data.num_a);
    assign vb = take_value(i_data.den_a);
    assign vc = take_value(i_data.num_b);
    assign vd = take_value(i_data.den_b);

    always_comb begin
        case (r_st)
            S_MUL1: begin
                mul_x = r_ma;
                mul_y = (r_op == OP_MUL) ? r_mc : r_md;
            end
            S_MUL2: begin
                mul_x = r_mb;
                mul_y = r_mc;
            end
            default: begin
                mul_x = r_mb;
                mul_y = (r_op == OP_DIV) ? r_mc : r_md;
            end
        endcase
    end

    rna_mul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .o_prod (m_prod)
    );

    always_comb begin
        s1       = r_sa ^ r_sd;
        s2       = s1;
        dneg     = r_sb ^ r_sd;
        two_term = 1'b0;
        case (r_op)
            OP_ADD: begin
                s2       = r_sb ^ r_sc;
                two_term = 1'b1;
            end
            OP_SUB: begin
                s2       = ~(r_sb ^ r_sc);
                two_term = 1'b1;
            end
            OP_MUL: begin
                s1 = r_sa ^ r_sc;
                s2 = s1;
            end
            OP_DIV: begin
                dneg = r_sb ^ r_sc;
            end
            OP_CMP: begin
                s1       = r_sa ^ r_sb;
                s2       = ~(r_sc ^ r_sd);
                two_term = 1'b1;
            end
            default: begin
                two_term = 1'b0;
            end
        endcase
    end

    assign m2    = two_term ? r_p2 : '0;
    assign add_y = {1'b0, r_p1} + {1'b0, m2};
    assign d12   = {1'b0, r_p1} - {1'b0, m2};
    assign d21   = {1'b0, m2} - {1'b0, r_p1};

    always_comb begin
        if (s1 == s2) begin
            sum_mag = add_y[MW-1:0];
            sum_neg = s1;
        end else if (!d12[MW]) begin
            sum_mag = d12[MW-1:0];
            sum_neg = s1;
        end else begin
            sum_mag = d21[MW-1:0];
            sum_neg = s2;
        end
    end

    rna_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_nmag  (r_nm),
        .i_dmag  (r_dm),
        .o_done  (core_done),
        .o_nq    (core_nq),
        .o_dq    (core_dq)
    );

    assign nq_ext     = LIM_W'(core_nq);
    assign dq_ext     = LIM_W'(core_dq);
    assign num_abs    = nq_ext[NUM_W-1:0];
    assign range_fail = (dq_ext > DEN_MAX) ||
                        (nq_ext > (r_neg ? NUM_NEG_MAX : NUM_POS_MAX));

    always_comb begin
        n_st     = r_st;
        n_op     = r_op;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_mc     = r_mc;
        n_md     = r_md;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_sc     = r_sc;
        n_sd     = r_sd;
        n_p1     = r_p1;
        n_p2     = r_p2;
        n_nm     = r_nm;
        n_dm     = r_dm;
        n_neg    = r_neg;
        n_go     = 1'b0;
        n_strobe = 1'b0;
        n_out    = r_out;
        case (r_st)
            S_IDLE: begin
                if (start) begin
                    n_op = i_data.opcode;
                    n_ma = magnitude(va);
                    n_mb = magnitude(vb);
                    n_mc = magnitude(vc);
                    n_md = magnitude(vd);
                    n_sa = va[VW-1];
                    n_sb = vb[VW-1];
                    n_sc = vc[VW-1];
                    n_sd = vd[VW-1];
                    n_out = '0;
                    if (i_data.opcode > OP_CMP) begin
                        n_strobe = 1'b1;
                    end else if (vb == '0 || vd == '0) begin
                        n_out.status = ST_ZERO_DEN;
                        n_strobe     = 1'b1;
                    end else if (i_data.opcode == OP_DIV && vc == '0) begin
                        n_out.status = ST_DIV_ZERO;
                        n_strobe     = 1'b1;
                    end else begin
                        n_st = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                n_st = S_MUL2;
            end
            S_MUL2: begin
                n_p1 = m_prod;
                n_st = S_MUL3;
            end
            S_MUL3: begin
                n_p2 = m_prod;
                n_st = S_COMB;
            end
            S_COMB: begin
                n_nm  = sum_mag;
                n_dm  = m_prod;
                n_neg = (r_op == OP_CMP) ? sum_neg : (sum_neg ^ dneg);
                n_st  = S_CHECK;
            end
            S_CHECK: begin
                n_out = '0;
                if (r_op == OP_CMP) begin
                    if (r_nm == '0) begin
                        n_out.order = ORD_EQ;
                    end else if (r_neg) begin
                        n_out.order = ORD_LT;
                    end else begin
                        n_out.order = ORD_GT;
                    end
                    n_strobe = 1'b1;
                    n_st     = S_IDLE;
                end else if (r_nm == '0) begin
                    n_out.res_den = DEN_W'(1);
                    n_strobe      = 1'b1;
                    n_st          = S_IDLE;
                end else begin
                    n_go = 1'b1;
                    n_st = S_CORE;
                end
            end
            S_CORE: begin
                if (core_done) begin
                    n_out = '0;
                    if (range_fail) begin
                        n_out.status = ST_RANGE;
                    end else begin
                        n_out.res_num = r_neg ? (~num_abs + 1'b1) : num_abs;
                        n_out.res_den = dq_ext[DEN_W-1:0];
                    end
                    n_strobe = 1'b1;
                    n_st     = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_go     <= n_go;
            r_strobe <= n_strobe;
        end
        r_op  <= n_op;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_mc  <= n_mc;
        r_md  <= n_md;
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_sc  <= n_sc;
        r_sd  <= n_sd;
        r_p1  <= n_p1;
        r_p2  <= n_p2;
        r_nm  <= n_nm;
        r_dm  <= n_dm;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    assign busy     = (r_st != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_data   = r_out;

endmodule

@@ hdl/rna_checker.sv @@
// Port-level checks for the rational number ALU, attached to the top level by bind.
// Depends on rna_pkg and rational_number_alu.
module rna_checker import rna_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_word  i_data,
    input logic      o_strobe,
    input t_out_word o_data
);

    // A zero denominator is answered at once with its own status.
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_data.opcode <= OP_CMP &&
         (i_data.den_a == '0 || i_data.den_b == '0))
        |=> (o_strobe && o_data.status == ST_ZERO_DEN))
        else $error("zero denominator not reported in the next word");

    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_data.opcode > OP_CMP) |=> (o_strobe && o_data == '0))
        else $error("unused opcode did not give an all-zero word");

    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_data.status != ST_OK)
        |-> (o_data.res_num == '0 && o_data.res_den == '0 && o_data.order == ORD_EQ))
        else $error("error word carries a value");

    // A zero result with a nonzero denominator is always reduced to 0/1.
    a_zero_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_data.status == ST_OK && o_data.res_num == '0 &&
         o_data.res_den != '0)
        |-> (o_data.res_den == DEN_W'(1)))
        else $error("zero result not reduced");

    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

endmodule

bind rational_number_alu rna_checker u_rna_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_data   (i_data),
    .o_strobe (o_strobe),
    .o_data   (o_data)
);
